### hw/rtl/css_pkg.sv
// ----------------------------------------------------------------------------
// Cardinal spline sampler package
// Shared widths, register indexes, reset values and the configuration bundle.
// ----------------------------------------------------------------------------
package css_pkg;

  localparam int INFL_W      = 6;
  localparam int TENS_W      = 18;
  localparam int STEP_W      = 17;
  localparam int CFG_W       = 18;
  localparam int CFG_IDX_W   = 2;
  localparam int TACC_W      = INFL_W + STEP_W;
  localparam int FRAC_W      = 16;
  localparam int Q16_ONE     = 65536;
  localparam int Q16_HALF    = 32768;
  localparam int N_AXES      = 3;
  localparam int N_PTS       = 4;
  localparam int N_COEF      = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INFLATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TENSION   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP      = 2'd2;

  localparam logic [INFL_W-1:0] INFL_RST = 6'd7;
  localparam logic [TENS_W-1:0] TENS_RST = 18'd32768;
  localparam logic [STEP_W-1:0] STEP_RST = 17'd8192;

  typedef struct packed {
    logic [INFL_W-1:0] inflation;
    logic [TENS_W-1:0] tension;
    logic [STEP_W-1:0] step;
  } cfg_t;

endpackage

### hw/rtl/css_front.sv
// ----------------------------------------------------------------------------
// Cardinal spline sampler front end
// Accepts segments and forms the per-axis spline coefficients in three stages.
// ----------------------------------------------------------------------------
module css_front #(
  parameter int COORD_BITS = 32,
  parameter int CW         = 48
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  css_pkg::cfg_t                         cfg_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [COORD_BITS-1:0]          pt_i [css_pkg::N_PTS][css_pkg::N_AXES],
  output logic                                  push_o,
  input  logic                                  push_rdy_i,
  output logic [css_pkg::N_AXES*css_pkg::N_COEF*CW-1:0] coef_o
);
  import css_pkg::*;

  localparam int EW = COORD_BITS + 3;
  localparam int PW = EW + TENS_W + 1;

  logic adv;
  logic va_q, vb_q, vc_q;

  logic signed [COORD_BITS-1:0] a_p1_d [N_AXES];
  logic signed [COORD_BITS-1:0] a_p1_q [N_AXES];
  logic signed [EW-1:0] a_d1_d [N_AXES], a_d1_q [N_AXES];
  logic signed [EW-1:0] a_d2_d [N_AXES], a_d2_q [N_AXES];
  logic signed [EW-1:0] a_e2_d [N_AXES], a_e2_q [N_AXES];
  logic signed [EW-1:0] a_d3_d [N_AXES], a_d3_q [N_AXES];
  logic signed [EW-1:0] a_e3_d [N_AXES], a_e3_q [N_AXES];

  logic signed [PW-1:0] b_m1_d [N_AXES], b_m1_q [N_AXES];
  logic signed [PW-1:0] b_m2_d [N_AXES], b_m2_q [N_AXES];
  logic signed [PW-1:0] b_m3_d [N_AXES], b_m3_q [N_AXES];
  logic signed [COORD_BITS-1:0] b_p1_q [N_AXES];
  logic signed [EW-1:0] b_d2_q [N_AXES], b_d3_q [N_AXES];

  logic [N_AXES*N_COEF*CW-1:0] coef_d, coef_q;

  function automatic logic signed [CW-1:0] rnd16(input logic signed [PW-1:0] m);
    logic signed [PW-1:0] s;
    s = (m + PW'(Q16_HALF)) >>> FRAC_W;
    return CW'(s);
  endfunction

  assign adv        = !vc_q || push_rdy_i;
  assign in_stall_o = !adv;
  assign push_o     = vc_q;
  assign coef_o     = coef_q;

  always_comb begin
    logic signed [EW-1:0] p0, p1, p2, p3, diff;
    logic signed [TENS_W:0] tau;
    tau = $signed({1'b0, cfg_i.tension});
    for (int a = 0; a < N_AXES; a++) begin
      p0 = EW'(pt_i[0][a]);
      p1 = EW'(pt_i[1][a]);
      p2 = EW'(pt_i[2][a]);
      p3 = EW'(pt_i[3][a]);
      diff = p2 - p1;
      a_p1_d[a] = pt_i[1][a];
      a_d1_d[a] = p2 - p0;
      a_d2_d[a] = diff + (diff <<< 1);
      a_e2_d[a] = (p0 <<< 1) + p1 - (p2 <<< 1) - p3;
      a_d3_d[a] = (p1 - p2) <<< 1;
      a_e3_d[a] = p2 + p3 - p0 - p1;
      b_m1_d[a] = PW'(a_d1_q[a]) * PW'(tau);
      b_m2_d[a] = PW'(a_e2_q[a]) * PW'(tau);
      b_m3_d[a] = PW'(a_e3_q[a]) * PW'(tau);
      coef_d[(a*N_COEF+0)*CW +: CW] = CW'(b_p1_q[a]);
      coef_d[(a*N_COEF+1)*CW +: CW] = rnd16(b_m1_q[a]);
      coef_d[(a*N_COEF+2)*CW +: CW] = CW'(b_d2_q[a]) + rnd16(b_m2_q[a]);
      coef_d[(a*N_COEF+3)*CW +: CW] = CW'(b_d3_q[a]) + rnd16(b_m3_q[a]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < N_AXES; a++) begin
        a_p1_q[a] <= a_p1_d[a];
        a_d1_q[a] <= a_d1_d[a];
        a_d2_q[a] <= a_d2_d[a];
        a_e2_q[a] <= a_e2_d[a];
        a_d3_q[a] <= a_d3_d[a];
        a_e3_q[a] <= a_e3_d[a];
        b_p1_q[a] <= a_p1_q[a];
        b_d2_q[a] <= a_d2_q[a];
        b_d3_q[a] <= a_d3_q[a];
        b_m1_q[a] <= b_m1_d[a];
        b_m2_q[a] <= b_m2_d[a];
        b_m3_q[a] <= b_m3_d[a];
      end
      coef_q <= coef_d;
    end
  end

endmodule

### hw/rtl/css_coef_fifo.sv
// ----------------------------------------------------------------------------
// Cardinal spline sampler coefficient queue
// Short queue of coefficient sets between front end and sample engine.
// ----------------------------------------------------------------------------
module css_coef_fifo #(
  parameter int WIDTH = 576
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  output logic             push_rdy_o,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             head_valid_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] head_o
);
  import css_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             full, wr_en;

  assign full         = (cnt_q == CNT_W'(QUEUE_DEPTH));
  assign push_rdy_o   = !full || pop_i;
  assign wr_en        = push_i && push_rdy_o;
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_en ? wr_ptr_q + PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(wr_en) - CNT_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> cnt_q != '0)
    else $error("pop from empty coefficient queue");
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CNT_W'(QUEUE_DEPTH))
    else $error("coefficient queue overfilled");

endmodule

### hw/rtl/css_back.sv
// ----------------------------------------------------------------------------
// Cardinal spline sampler engine
// Steps t over one segment and evaluates the cubic per axis in a Horner pipe.
// ----------------------------------------------------------------------------
module css_back #(
  parameter int COORD_BITS = 32,
  parameter int CW         = 48
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  css_pkg::cfg_t                         cfg_i,
  input  logic                                  head_valid_i,
  input  logic [css_pkg::N_AXES*css_pkg::N_COEF*CW-1:0] head_i,
  output logic                                  pop_o,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [COORD_BITS-1:0]          out_o [css_pkg::N_AXES],
  output logic                                  out_last_o
);
  import css_pkg::*;

  localparam int MW = CW + STEP_W + 1;
  localparam logic signed [CW-1:0] SAT_MAX =
    {{(CW-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
  localparam logic signed [CW-1:0] SAT_MIN =
    {{(CW-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};

  logic              adv, issue, last_cur;
  logic [STEP_W-1:0] t_cur;
  logic [INFL_W-1:0] l_q, l_d;
  logic [TACC_W-1:0] tacc_q, tacc_d;

  logic signed [CW-1:0] hc [N_AXES][N_COEF];

  logic v1_q, v2_q, v3_q, v4_q, v5_q, out_valid_q;
  logic last1_q, last2_q, last3_q, last4_q, last5_q, out_last_q;
  logic [STEP_W-1:0] t1_q, t2_q, t3_q, t4_q;

  logic signed [CW-1:0] c0_1_q [N_AXES], c1_1_q [N_AXES], c2_1_q [N_AXES];
  logic signed [MW-1:0] m1_d [N_AXES], m1_q [N_AXES];
  logic signed [CW-1:0] c0_2_q [N_AXES], c1_2_q [N_AXES];
  logic signed [CW-1:0] acc2_d [N_AXES], acc2_q [N_AXES];
  logic signed [CW-1:0] c0_3_q [N_AXES], c1_3_q [N_AXES];
  logic signed [MW-1:0] m3_d [N_AXES], m3_q [N_AXES];
  logic signed [CW-1:0] c0_4_q [N_AXES];
  logic signed [CW-1:0] acc4_d [N_AXES], acc4_q [N_AXES];
  logic signed [CW-1:0] c0_5_q [N_AXES];
  logic signed [MW-1:0] m5_d [N_AXES], m5_q [N_AXES];
  logic signed [COORD_BITS-1:0] out_d [N_AXES], out_q [N_AXES];

  function automatic logic signed [CW-1:0] rnd16(input logic signed [MW-1:0] m);
    logic signed [MW-1:0] s;
    s = (m + MW'(Q16_HALF)) >>> FRAC_W;
    return CW'(s);
  endfunction

  function automatic logic signed [STEP_W:0] tsgn(input logic [STEP_W-1:0] t);
    return $signed({1'b0, t});
  endfunction

  assign adv      = !out_valid_q || !out_stall_i;
  assign issue    = head_valid_i && adv;
  assign last_cur = (l_q == cfg_i.inflation);
  assign t_cur    = (tacc_q > TACC_W'(Q16_ONE)) ? STEP_W'(Q16_ONE) : tacc_q[STEP_W-1:0];
  assign pop_o    = issue && last_cur;

  assign out_valid_o = out_valid_q;
  assign out_last_o  = out_last_q;
  assign out_o       = out_q;

  always_comb begin
    l_d    = l_q;
    tacc_d = tacc_q;
    if (issue) begin
      if (last_cur) begin
        l_d    = '0;
        tacc_d = '0;
      end else begin
        l_d    = l_q + INFL_W'(1);
        tacc_d = tacc_q + TACC_W'(cfg_i.step);
      end
    end
  end

  always_comb begin
    logic signed [CW-1:0] acc6;
    for (int a = 0; a < N_AXES; a++) begin
      for (int k = 0; k < N_COEF; k++) begin
        hc[a][k] = $signed(head_i[(a*N_COEF+k)*CW +: CW]);
      end
      m1_d[a]   = MW'(hc[a][3]) * MW'(tsgn(t_cur));
      acc2_d[a] = rnd16(m1_q[a]) + c2_1_q[a];
      m3_d[a]   = MW'(acc2_q[a]) * MW'(tsgn(t2_q));
      acc4_d[a] = rnd16(m3_q[a]) + c1_3_q[a];
      m5_d[a]   = MW'(acc4_q[a]) * MW'(tsgn(t4_q));
      acc6      = rnd16(m5_q[a]) + c0_5_q[a];
      if (acc6 > SAT_MAX) begin
        out_d[a] = COORD_BITS'(SAT_MAX);
      end else if (acc6 < SAT_MIN) begin
        out_d[a] = COORD_BITS'(SAT_MIN);
      end else begin
        out_d[a] = COORD_BITS'(acc6);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l_q         <= '0;
      tacc_q      <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      l_q    <= l_d;
      tacc_q <= tacc_d;
      if (adv) begin
        v1_q        <= head_valid_i;
        v2_q        <= v1_q;
        v3_q        <= v2_q;
        v4_q        <= v3_q;
        v5_q        <= v4_q;
        out_valid_q <= v5_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      last1_q    <= last_cur;
      last2_q    <= last1_q;
      last3_q    <= last2_q;
      last4_q    <= last3_q;
      last5_q    <= last4_q;
      out_last_q <= last5_q;
      t1_q <= t_cur;
      t2_q <= t1_q;
      t3_q <= t2_q;
      t4_q <= t3_q;
      for (int a = 0; a < N_AXES; a++) begin
        c0_1_q[a] <= hc[a][0];
        c1_1_q[a] <= hc[a][1];
        c2_1_q[a] <= hc[a][2];
        m1_q[a]   <= m1_d[a];
        c0_2_q[a] <= c0_1_q[a];
        c1_2_q[a] <= c1_1_q[a];
        acc2_q[a] <= acc2_d[a];
        c0_3_q[a] <= c0_2_q[a];
        c1_3_q[a] <= c1_2_q[a];
        m3_q[a]   <= m3_d[a];
        c0_4_q[a] <= c0_3_q[a];
        acc4_q[a] <= acc4_d[a];
        c0_5_q[a] <= c0_4_q[a];
        m5_q[a]   <= m5_d[a];
        out_q[a]  <= out_d[a];
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_o |-> head_valid_i)
    else $error("segment retired without a queued segment");
  assert property (@(posedge clk_i) disable iff (!rst_ni) l_q <= cfg_i.inflation)
    else $error("sample index beyond segment length");

endmodule

### hw/rtl/cardinal_spline_segment_sampler_core.sv
// ----------------------------------------------------------------------------
// Cardinal spline segment sampler
// Takes four 3-D control points per segment and emits inflation+1 samples.
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | payload
//  in      | input     | in_valid_i / in_stall_o | prev_*, start_*, end_*, after_*
//  out     | output    | out_valid_o/out_stall_i | out_x/y/z, last_sample
//  cfg     | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
//  The sample engine issues one sample a cycle while the output is not stalled;
//  a queued segment follows the previous one with no gap. An accepted segment
//  passes three coefficient stages, the queue and six Horner stages to its first
//  sample. Reset loads the register defaults and empties all stages. An output
//  stall on a valid sample freezes the sample engine; the front end keeps accepting
//  until the two-entry queue is full and the third coefficient stage is loaded.
// ----------------------------------------------------------------------------
module cardinal_spline_segment_sampler_core #(
  parameter int COORD_BITS = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [css_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [css_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_BITS-1:0]      prev_x_i,
  input  logic signed [COORD_BITS-1:0]      prev_y_i,
  input  logic signed [COORD_BITS-1:0]      prev_z_i,
  input  logic signed [COORD_BITS-1:0]      start_x_i,
  input  logic signed [COORD_BITS-1:0]      start_y_i,
  input  logic signed [COORD_BITS-1:0]      start_z_i,
  input  logic signed [COORD_BITS-1:0]      end_x_i,
  input  logic signed [COORD_BITS-1:0]      end_y_i,
  input  logic signed [COORD_BITS-1:0]      end_z_i,
  input  logic signed [COORD_BITS-1:0]      after_x_i,
  input  logic signed [COORD_BITS-1:0]      after_y_i,
  input  logic signed [COORD_BITS-1:0]      after_z_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [COORD_BITS-1:0]      out_x_o,
  output logic signed [COORD_BITS-1:0]      out_y_o,
  output logic signed [COORD_BITS-1:0]      out_z_o,
  output logic                              last_sample_o
);
  import css_pkg::*;

  localparam int CW   = COORD_BITS + 16;
  localparam int QW   = N_AXES * N_COEF * CW;

  logic [INFL_W-1:0] infl_q;
  logic [TENS_W-1:0] tens_q;
  logic [STEP_W-1:0] step_q;
  cfg_t              cfg;

  logic signed [COORD_BITS-1:0] pt [N_PTS][N_AXES];
  logic signed [COORD_BITS-1:0] res [N_AXES];

  logic          push, push_rdy, head_valid, pop;
  logic [QW-1:0] coef, head;

  assign cfg = '{inflation: infl_q, tension: tens_q, step: step_q};

  assign pt[0][0] = prev_x_i;
  assign pt[0][1] = prev_y_i;
  assign pt[0][2] = prev_z_i;
  assign pt[1][0] = start_x_i;
  assign pt[1][1] = start_y_i;
  assign pt[1][2] = start_z_i;
  assign pt[2][0] = end_x_i;
  assign pt[2][1] = end_y_i;
  assign pt[2][2] = end_z_i;
  assign pt[3][0] = after_x_i;
  assign pt[3][1] = after_y_i;
  assign pt[3][2] = after_z_i;

  assign out_x_o = res[0];
  assign out_y_o = res[1];
  assign out_z_o = res[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infl_q <= INFL_RST;
      tens_q <= TENS_RST;
      step_q <= STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_INFLATION: infl_q <= cfg_data_i[INFL_W-1:0];
        REG_TENSION:   tens_q <= cfg_data_i[TENS_W-1:0];
        REG_STEP:      step_q <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  css_front #(
    .COORD_BITS(COORD_BITS),
    .CW        (CW)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .pt_i      (pt),
    .push_o    (push),
    .push_rdy_i(push_rdy),
    .coef_o    (coef)
  );

  css_coef_fifo #(
    .WIDTH(QW)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_rdy_o  (push_rdy),
    .wdata_i     (coef),
    .head_valid_o(head_valid),
    .pop_i       (pop),
    .head_o      (head)
  );

  css_back #(
    .COORD_BITS(COORD_BITS),
    .CW        (CW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .head_valid_i(head_valid),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res),
    .out_last_o  (last_sample_o)
  );

endmodule

### tb/cardinal_spline_segment_sampler_core_test.sv
// ----------------------------------------------------------------------------
// Cardinal spline segment sampler testbench
// Sends curve segments through the valid/stall input channel and checks every
// output sample against an in-bench spline evaluator that tracks the register
// writes. Register defaults and extremes come first, then random segments under
// random source gaps and sink stalls, a long sink hold-off and a gap-free run.
// ----------------------------------------------------------------------------
module cardinal_spline_segment_sampler_core_test;
  import css_pkg::*;

  localparam int COORD_BITS     = 32;
  localparam int N_COORDS       = N_PTS * N_AXES;
  localparam int PT_PREV        = 0;
  localparam int PT_START       = 1;
  localparam int PT_END         = 2;
  localparam int PT_AFTER       = 3;
  localparam int HOLD_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 30;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [COORD_BITS-1:0] COORD_MAX  = 32'h7FFF_FFFF;
  localparam logic [COORD_BITS-1:0] COORD_MIN  = 32'h8000_0000;
  localparam logic [COORD_BITS-1:0] COORD_ONE  = 32'h0100_0000;
  localparam logic [COORD_BITS-1:0] COORD_TWO  = 32'h0200_0000;
  localparam logic [COORD_BITS-1:0] COORD_NEG1 = 32'hFF00_0000;

  typedef logic [N_COORDS-1:0][COORD_BITS-1:0] segment_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] z;
    logic                  last;
  } sample_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_W-1:0]      cfg_data_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [COORD_BITS-1:0] prev_x_i = '0;
  logic [COORD_BITS-1:0] prev_y_i = '0;
  logic [COORD_BITS-1:0] prev_z_i = '0;
  logic [COORD_BITS-1:0] start_x_i = '0;
  logic [COORD_BITS-1:0] start_y_i = '0;
  logic [COORD_BITS-1:0] start_z_i = '0;
  logic [COORD_BITS-1:0] end_x_i = '0;
  logic [COORD_BITS-1:0] end_y_i = '0;
  logic [COORD_BITS-1:0] end_z_i = '0;
  logic [COORD_BITS-1:0] after_x_i = '0;
  logic [COORD_BITS-1:0] after_y_i = '0;
  logic [COORD_BITS-1:0] after_z_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [COORD_BITS-1:0] out_x_o;
  logic [COORD_BITS-1:0] out_y_o;
  logic [COORD_BITS-1:0] out_z_o;
  logic                  last_sample_o;

  logic [INFL_W-1:0] cfg_inflation = INFL_RST;
  logic [TENS_W-1:0] cfg_tension   = TENS_RST;
  logic [STEP_W-1:0] cfg_step      = STEP_RST;

  sample_t pending_samples[$];
  int      fail_count = 0;
  int      quiet_cycles = 0;
  bit      src_gaps = 1'b0;
  bit      sink_gaps = 1'b0;
  bit      sink_hold_req = 1'b0;

  cardinal_spline_segment_sampler_core #(
    .COORD_BITS(COORD_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .prev_x_i     (prev_x_i),
    .prev_y_i     (prev_y_i),
    .prev_z_i     (prev_z_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .start_z_i    (start_z_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .end_z_i      (end_z_i),
    .after_x_i    (after_x_i),
    .after_y_i    (after_y_i),
    .after_z_i    (after_z_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_x_o      (out_x_o),
    .out_y_o      (out_y_o),
    .out_z_o      (out_z_o),
    .last_sample_o(last_sample_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // round(a * b / 2^16), ties toward plus infinity
  function automatic longint scale_q16(input longint a, input longint b);
    longint hi;
    longint lo;
    hi = a >>> FRAC_W;
    lo = a - (hi <<< FRAC_W);
    return hi * b + ((lo * b + Q16_HALF) >>> FRAC_W);
  endfunction

  function automatic logic [COORD_BITS-1:0] saturate_coord(input longint v);
    longint hi_lim;
    longint lo_lim;
    hi_lim = (longint'(1) <<< (COORD_BITS - 1)) - 1;
    lo_lim = -(longint'(1) <<< (COORD_BITS - 1));
    if (v > hi_lim) v = hi_lim;
    if (v < lo_lim) v = lo_lim;
    return v[COORD_BITS-1:0];
  endfunction

  function automatic void predict_samples(input segment_t seg);
    longint                coef[N_AXES][N_COEF];
    longint                p0, p1, p2, p3;
    longint                tau, stepv, t, acc;
    logic [COORD_BITS-1:0] pos[N_AXES];
    sample_t               s;
    tau = cfg_tension;
    stepv = cfg_step;
    for (int a = 0; a < N_AXES; a++) begin
      p0 = longint'($signed(seg[PT_PREV*N_AXES+a]));
      p1 = longint'($signed(seg[PT_START*N_AXES+a]));
      p2 = longint'($signed(seg[PT_END*N_AXES+a]));
      p3 = longint'($signed(seg[PT_AFTER*N_AXES+a]));
      coef[a][0] = p1;
      coef[a][1] = scale_q16(p2 - p0, tau);
      coef[a][2] = 3 * (p2 - p1) + scale_q16(2 * p0 + p1 - 2 * p2 - p3, tau);
      coef[a][3] = 2 * (p1 - p2) + scale_q16(p2 + p3 - p0 - p1, tau);
    end
    for (int l = 0; l <= int'(cfg_inflation); l++) begin
      t = l * stepv;
      if (t > Q16_ONE) t = Q16_ONE;
      for (int a = 0; a < N_AXES; a++) begin
        acc = coef[a][3];
        acc = scale_q16(acc, t) + coef[a][2];
        acc = scale_q16(acc, t) + coef[a][1];
        acc = scale_q16(acc, t) + coef[a][0];
        pos[a] = saturate_coord(acc);
      end
      s.x = pos[0];
      s.y = pos[1];
      s.z = pos[2];
      s.last = (l == int'(cfg_inflation));
      pending_samples.push_back(s);
    end
  endfunction

  function automatic segment_t uniform_segment(input logic [COORD_BITS-1:0] lead,
                                               input logic [COORD_BITS-1:0] head,
                                               input logic [COORD_BITS-1:0] tail,
                                               input logic [COORD_BITS-1:0] trail);
    segment_t seg;
    for (int a = 0; a < N_AXES; a++) begin
      seg[PT_PREV*N_AXES+a]  = lead;
      seg[PT_START*N_AXES+a] = head;
      seg[PT_END*N_AXES+a]   = tail;
      seg[PT_AFTER*N_AXES+a] = trail;
    end
    return seg;
  endfunction

  // mostly smooth point runs along a random direction, some raw noise and rails
  function automatic segment_t random_segment();
    segment_t seg;
    longint   base, delta, jitter;
    int       kind;
    kind = $urandom_range(0, 9);
    for (int a = 0; a < N_AXES; a++) begin
      base = $urandom_range(0, 1 << 30);
      base = base - (1 << 29);
      delta = $urandom_range(0, 1 << 27);
      delta = delta - (1 << 26);
      for (int p = 0; p < N_PTS; p++) begin
        jitter = $urandom_range(0, 1 << 22);
        jitter = jitter - (1 << 21);
        if (kind == 0) begin
          seg[p*N_AXES+a] = $urandom();
        end else if (kind == 1) begin
          seg[p*N_AXES+a] = $urandom_range(0, 1) ? COORD_MAX : COORD_MIN;
        end else begin
          seg[p*N_AXES+a] = COORD_BITS'(base + p * delta + jitter);
        end
      end
    end
    return seg;
  endfunction

  task automatic send_segment(input segment_t seg);
    @(negedge clk_i);
    if (src_gaps && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    prev_x_i   <= seg[PT_PREV*N_AXES+0];
    prev_y_i   <= seg[PT_PREV*N_AXES+1];
    prev_z_i   <= seg[PT_PREV*N_AXES+2];
    start_x_i  <= seg[PT_START*N_AXES+0];
    start_y_i  <= seg[PT_START*N_AXES+1];
    start_z_i  <= seg[PT_START*N_AXES+2];
    end_x_i    <= seg[PT_END*N_AXES+0];
    end_y_i    <= seg[PT_END*N_AXES+1];
    end_z_i    <= seg[PT_END*N_AXES+2];
    after_x_i  <= seg[PT_AFTER*N_AXES+0];
    after_y_i  <= seg[PT_AFTER*N_AXES+1];
    after_z_i  <= seg[PT_AFTER*N_AXES+2];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_samples(seg);
  endtask

  task automatic settle_outputs();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_samples.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_INFLATION: cfg_inflation = data[INFL_W-1:0];
      REG_TENSION:   cfg_tension   = data[TENS_W-1:0];
      REG_STEP:      cfg_step      = data[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic program_random_config();
    int infl;
    int tens;
    int stp;
    infl = ($urandom_range(0, 5) == 0) ? 63 : $urandom_range(0, 15);
    case ($urandom_range(0, 4))
      0:       tens = 0;
      1:       tens = 131072;
      2:       tens = $urandom_range(131073, 262143);
      default: tens = $urandom_range(0, 131072);
    endcase
    stp = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 131071) : Q16_ONE / (infl + 1);
    write_reg(REG_INFLATION, CFG_W'(infl));
    write_reg(REG_TENSION, CFG_W'(tens));
    write_reg(REG_STEP, CFG_W'(stp));
  endtask

  task automatic test_default_registers();
    send_segment(uniform_segment('0, '0, '0, '0));
    send_segment(uniform_segment(COORD_NEG1, '0, COORD_ONE, COORD_TWO));
    send_segment(uniform_segment(COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
    send_segment(uniform_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN));
    send_segment(uniform_segment(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    send_segment(uniform_segment(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
    settle_outputs();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_INFLATION, '0);
    write_reg(REG_TENSION, '0);
    write_reg(REG_STEP, '0);
    send_segment(uniform_segment(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    send_segment(uniform_segment(COORD_NEG1, '0, COORD_ONE, COORD_TWO));
    settle_outputs();
    write_reg(REG_INFLATION, 18'h3FFFF);
    write_reg(REG_TENSION, 18'd131072);
    write_reg(REG_STEP, 18'd1024);
    send_segment(uniform_segment(COORD_NEG1, '0, COORD_ONE, COORD_TWO));
    send_segment(uniform_segment(COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
    settle_outputs();
    write_reg(REG_INFLATION, 18'h3FFC3);
    write_reg(REG_TENSION, 18'h3FFFF);
    write_reg(REG_STEP, 18'd65536);
    send_segment(uniform_segment(COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
    send_segment(random_segment());
    settle_outputs();
    write_reg(REG_STEP, 18'h1FFFF);
    write_reg(REG_UNUSED, 18'h2AAAA);
    write_reg(REG_INFLATION, 18'd5);
    send_segment(uniform_segment(COORD_NEG1, '0, COORD_ONE, COORD_TWO));
    send_segment(random_segment());
    settle_outputs();
  endtask

  task automatic test_random_segments();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    for (int phase = 0; phase < 8; phase++) begin
      program_random_config();
      repeat (25) send_segment(random_segment());
      settle_outputs();
    end
  endtask

  task automatic test_output_backpressure();
    src_gaps      = 1'b0;
    sink_hold_req = 1'b1;
    repeat (16) send_segment(random_segment());
    settle_outputs();
  endtask

  task automatic test_steady_stream();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    program_random_config();
    repeat (50) send_segment(random_segment());
    settle_outputs();
  endtask

  initial begin : sink_stall
    int held;
    forever begin
      @(negedge clk_i);
      if (sink_hold_req) begin
        out_stall_i <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk_i);
        sink_hold_req = 1'b0;
        out_stall_i <= 1'b0;
      end else if (sink_gaps && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : sample_check
    sample_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_samples.size() == 0) begin
        $display("%0t: unexpected sample x=%h y=%h z=%h last=%b", $time,
                 out_x_o, out_y_o, out_z_o, last_sample_o);
        fail_count++;
      end else begin
        want = pending_samples.pop_front();
        if (out_x_o !== want.x) begin
          $display("%0t: out_x expected %h actual %h", $time, want.x, out_x_o);
          fail_count++;
        end
        if (out_y_o !== want.y) begin
          $display("%0t: out_y expected %h actual %h", $time, want.y, out_y_o);
          fail_count++;
        end
        if (out_z_o !== want.z) begin
          $display("%0t: out_z expected %h actual %h", $time, want.z, out_z_o);
          fail_count++;
        end
        if (last_sample_o !== want.last) begin
          $display("%0t: last_sample expected %b actual %b", $time, want.last,
                   last_sample_o);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, %0d samples still outstanding", $time, pending_samples.size());
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_default_registers();
    test_register_extremes();
    test_random_segments();
    test_output_backpressure();
    test_steady_stream();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending_samples.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
